// ----- hw/rtl/stereo_match_triangulator_assert.svh -----
// Assertion macros for the stereo match triangulator RTL.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef STEREO_MATCH_TRIANGULATOR_ASSERT_SVH
`define STEREO_MATCH_TRIANGULATOR_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define SMT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition is followed in the next cycle by a consequence.
`define SMT_ASSERT_NEXT(name, cond, conseq, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ----- hw/rtl/smt_pkg.sv -----
// ----------------------------------------------------------------------------
// smt_pkg
// Shared types, constants and codes of the stereo match triangulator.
// ----------------------------------------------------------------------------
package smt_pkg;

    localparam int PIXEL_FRAC_BITS    = 4;
    localparam int BASELINE_FRAC_BITS = 12;
    localparam int DEPTH_FRAC_BITS    = 16;
    localparam int DEPTH_SHIFT        = DEPTH_FRAC_BITS - BASELINE_FRAC_BITS;
    localparam int NUM_W              = 32 + DEPTH_SHIFT;
    localparam int QUOT_W             = 24;
    localparam int QUEUE_DEPTH        = 4;
    localparam int QUEUE_PTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] VERDICT_KEPT       = 3'd0;
    localparam logic [2:0] VERDICT_OFF_ROW    = 3'd1;
    localparam logic [2:0] VERDICT_NEG_DISP   = 3'd2;
    localparam logic [2:0] VERDICT_SMALL_DISP = 3'd3;
    localparam logic [2:0] VERDICT_TOO_FAR    = 3'd4;

    localparam logic [2:0] CFG_FOCAL_X       = 3'd0;
    localparam logic [2:0] CFG_FOCAL_Y       = 3'd1;
    localparam logic [2:0] CFG_CENTER_X      = 3'd2;
    localparam logic [2:0] CFG_CENTER_Y      = 3'd3;
    localparam logic [2:0] CFG_BASELINE      = 3'd4;
    localparam logic [2:0] CFG_ROW_TOLERANCE = 3'd5;
    localparam logic [2:0] CFG_MIN_DISPARITY = 3'd6;
    localparam logic [2:0] CFG_MAX_DEPTH     = 3'd7;

    typedef struct packed {
        logic [15:0] focal_x;
        logic [15:0] focal_y;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] baseline;
        logic [15:0] row_tolerance;
        logic [15:0] min_disparity;
        logic [23:0] max_depth;
    } cfg_t;

    // Classified pair handed from the front end to the arithmetic back end.
    typedef struct packed {
        logic [2:0]       verdict;
        logic [15:0]      disp;
        logic [NUM_W-1:0] num;
        logic             x_neg;
        logic [15:0]      x_mag;
        logic             y_neg;
        logic [15:0]      y_mag;
    } job_t;

endpackage

// ----- hw/rtl/smt_front.sv -----
// ----------------------------------------------------------------------------
// smt_front
// Registers incoming pairs, applies the row and disparity tests and forms
// the depth numerator.
// ----------------------------------------------------------------------------
module smt_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  smt_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [15:0]   left_col,
    input  logic [15:0]   left_row,
    input  logic [15:0]   right_col,
    input  logic [15:0]   right_row,
    input  logic          queue_full,
    output logic          push,
    output smt_pkg::job_t job
);
    import smt_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    job_t        job_reg;
    job_t        job_next;
    logic [15:0] row_diff;
    logic [31:0] focal_base;

    assign in_ready = !valid_reg || !queue_full;
    assign push     = valid_reg && !queue_full;
    assign job      = job_reg;

    always_comb
    begin
        row_diff   = (left_row >= right_row) ? left_row - right_row : right_row - left_row;
        focal_base = cfg.focal_x * cfg.baseline;
        job_next.disp  = left_col - right_col;
        job_next.num   = {focal_base, {DEPTH_SHIFT{1'b0}}};
        job_next.x_neg = left_col < cfg.center_x;
        job_next.x_mag = job_next.x_neg ? cfg.center_x - left_col : left_col - cfg.center_x;
        job_next.y_neg = left_row < cfg.center_y;
        job_next.y_mag = job_next.y_neg ? cfg.center_y - left_row : left_row - cfg.center_y;
        if (row_diff > cfg.row_tolerance)
        begin
            job_next.verdict = VERDICT_OFF_ROW;
        end
        else if (left_col < right_col)
        begin
            job_next.verdict = VERDICT_NEG_DISP;
        end
        else if (job_next.disp < cfg.min_disparity)
        begin
            job_next.verdict = VERDICT_SMALL_DISP;
        end
        else if (job_next.disp == 16'd0)
        begin
            // Zero disparity means infinite depth.
            job_next.verdict = VERDICT_TOO_FAR;
        end
        else
        begin
            job_next.verdict = VERDICT_KEPT;
        end
    end

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            job_reg <= job_next;
        end
    end

endmodule

// ----- hw/rtl/smt_queue.sv -----
// ----------------------------------------------------------------------------
// smt_queue
// Short queue of classified pairs between the front end and the back end.
// ----------------------------------------------------------------------------
`include "stereo_match_triangulator_assert.svh"

module smt_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  smt_pkg::job_t push_job,
    input  logic          pop,
    output smt_pkg::job_t pop_job,
    output logic          empty,
    output logic          full
);
    import smt_pkg::*;

    job_t                   mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic [QUEUE_PTR_W:0]   count_next;

    assign empty   = count_reg == '0;
    assign full    = count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
    assign pop_job = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_PTR_W+1)'(push) - (QUEUE_PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    `SMT_ASSERT(a_no_push_full, !(push && full), "push into a full queue")
    `SMT_ASSERT(a_no_pop_empty, !(pop && empty), "pop from an empty queue")
    `SMT_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not grow on push")

endmodule

// ----- hw/rtl/smt_back.sv -----
// ----------------------------------------------------------------------------
// smt_back
// Pipelined depth division, lateral products, pipelined projection
// divisions, saturation and the output register.
// ----------------------------------------------------------------------------
module smt_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  smt_pkg::cfg_t cfg,
    input  logic          queue_empty,
    input  smt_pkg::job_t job,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [2:0]    verdict,
    output logic [23:0]   point_x,
    output logic [23:0]   point_y,
    output logic [23:0]   point_z
);
    import smt_pkg::*;

    typedef struct packed {
        logic [2:0]        verdict;
        logic [15:0]       disp;
        logic [15:0]       rem;
        logic [QUOT_W-1:0] work;
        logic              x_neg;
        logic [15:0]       x_mag;
        logic              y_neg;
        logic [15:0]       y_mag;
    } zst_t;

    typedef struct packed {
        logic [2:0]        verdict;
        logic [23:0]       z;
        logic              x_neg;
        logic              x_sat;
        logic [15:0]       x_rem;
        logic [QUOT_W-1:0] x_work;
        logic              y_neg;
        logic              y_sat;
        logic [15:0]       y_rem;
        logic [QUOT_W-1:0] y_work;
    } pst_t;

    // One restoring division step: returns the new remainder and quotient bit.
    function automatic logic [16:0] div_step(logic [15:0] rem, logic in_bit,
                                             logic [15:0] divisor);
        logic [16:0] trial;
        logic [16:0] res;
        trial = {rem, in_bit};
        if (trial >= {1'b0, divisor})
        begin
            res = {16'(trial - {1'b0, divisor}), 1'b1};
        end
        else
        begin
            res = {trial[15:0], 1'b0};
        end
        return res;
    endfunction

    function automatic logic [23:0] saturate(logic neg, logic sat, logic [23:0] q);
        logic [23:0] mag;
        logic [23:0] res;
        if (neg)
        begin
            mag = (sat || q > 24'h800000) ? 24'h800000 : q;
            res = 24'(~mag + 24'd1);
        end
        else
        begin
            res = (sat || q[23]) ? 24'h7FFFFF : q;
        end
        return res;
    endfunction

    logic                advance;
    logic [QUOT_W:0]     zv_reg;
    zst_t                zst_reg [QUOT_W+1];
    zst_t                zst_nx  [QUOT_W];
    zst_t                zst_load;
    logic                p_v_reg;
    logic [2:0]          p_verdict_reg;
    logic [23:0]         p_z_reg;
    logic                p_x_neg_reg;
    logic                p_y_neg_reg;
    logic [39:0]         p_prod_x_reg;
    logic [39:0]         p_prod_y_reg;
    logic [QUOT_W:0]     pv_reg;
    pst_t                pst_reg [QUOT_W+1];
    pst_t                pst_nx  [QUOT_W];
    pst_t                pst_load;
    logic [16:0]         zs    [QUOT_W];
    logic [16:0]         xs    [QUOT_W];
    logic [16:0]         ys    [QUOT_W];
    logic [2:0]          z_verdict;
    logic                out_valid_reg;
    logic [2:0]          verdict_reg;
    logic [23:0]         point_x_reg;
    logic [23:0]         point_y_reg;
    logic [23:0]         point_z_reg;
    pst_t                last;

    assign advance   = !out_valid_reg || out_ready;
    assign pop       = advance && !queue_empty;
    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;
    assign point_z   = point_z_reg;
    assign last      = pst_reg[QUOT_W];

    always_comb
    begin
        zst_load.disp  = job.disp;
        zst_load.rem   = 16'(job.num[NUM_W-1:QUOT_W]);
        zst_load.work  = job.num[QUOT_W-1:0];
        zst_load.x_neg = job.x_neg;
        zst_load.x_mag = job.x_mag;
        zst_load.y_neg = job.y_neg;
        zst_load.y_mag = job.y_mag;
        // A quotient of 2^24 or more is beyond any depth limit.
        if (job.verdict == VERDICT_KEPT &&
            {{(40-NUM_W){1'b0}}, job.num} >= {job.disp, 24'd0})
        begin
            zst_load.verdict = VERDICT_TOO_FAR;
        end
        else
        begin
            zst_load.verdict = job.verdict;
        end
    end

    always_comb
    begin
        for (int i = 0; i < QUOT_W; i++)
        begin
            zs[i]          = div_step(zst_reg[i].rem, zst_reg[i].work[QUOT_W-1],
                                      zst_reg[i].disp);
            zst_nx[i]      = zst_reg[i];
            zst_nx[i].rem  = zs[i][16:1];
            zst_nx[i].work = {zst_reg[i].work[QUOT_W-2:0], zs[i][0]};
        end
    end

    always_comb
    begin
        z_verdict = zst_reg[QUOT_W].verdict;
        if (z_verdict == VERDICT_KEPT && zst_reg[QUOT_W].work > cfg.max_depth)
        begin
            z_verdict = VERDICT_TOO_FAR;
        end
    end

    always_comb
    begin
        pst_load.verdict = p_verdict_reg;
        pst_load.z       = p_z_reg;
        pst_load.x_neg   = p_x_neg_reg;
        pst_load.x_sat   = p_prod_x_reg >= {cfg.focal_x, 24'd0};
        pst_load.x_rem   = p_prod_x_reg[39:24];
        pst_load.x_work  = p_prod_x_reg[23:0];
        pst_load.y_neg   = p_y_neg_reg;
        pst_load.y_sat   = p_prod_y_reg >= {cfg.focal_y, 24'd0};
        pst_load.y_rem   = p_prod_y_reg[39:24];
        pst_load.y_work  = p_prod_y_reg[23:0];
    end

    always_comb
    begin
        for (int i = 0; i < QUOT_W; i++)
        begin
            xs[i] = div_step(pst_reg[i].x_rem, pst_reg[i].x_work[QUOT_W-1], cfg.focal_x);
            ys[i] = div_step(pst_reg[i].y_rem, pst_reg[i].y_work[QUOT_W-1], cfg.focal_y);
            pst_nx[i]        = pst_reg[i];
            pst_nx[i].x_rem  = xs[i][16:1];
            pst_nx[i].x_work = {pst_reg[i].x_work[QUOT_W-2:0], xs[i][0]};
            pst_nx[i].y_rem  = ys[i][16:1];
            pst_nx[i].y_work = {pst_reg[i].y_work[QUOT_W-2:0], ys[i][0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zv_reg        <= '0;
            p_v_reg       <= 1'b0;
            pv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            zv_reg        <= {zv_reg[QUOT_W-1:0], !queue_empty};
            p_v_reg       <= zv_reg[QUOT_W];
            pv_reg        <= {pv_reg[QUOT_W-1:0], p_v_reg};
            out_valid_reg <= pv_reg[QUOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            zst_reg[0] <= zst_load;
            for (int i = 0; i < QUOT_W; i++)
            begin
                zst_reg[i+1] <= zst_nx[i];
                pst_reg[i+1] <= pst_nx[i];
            end
            p_verdict_reg <= z_verdict;
            p_z_reg       <= zst_reg[QUOT_W].work;
            p_x_neg_reg   <= zst_reg[QUOT_W].x_neg;
            p_y_neg_reg   <= zst_reg[QUOT_W].y_neg;
            p_prod_x_reg  <= zst_reg[QUOT_W].x_mag * zst_reg[QUOT_W].work;
            p_prod_y_reg  <= zst_reg[QUOT_W].y_mag * zst_reg[QUOT_W].work;
            pst_reg[0]    <= pst_load;
            verdict_reg   <= last.verdict;
            if (last.verdict != VERDICT_KEPT)
            begin
                point_x_reg <= 24'd0;
                point_y_reg <= 24'd0;
                point_z_reg <= 24'd0;
            end
            else
            begin
                point_z_reg <= last.z;
                point_x_reg <= (cfg.focal_x == 16'd0) ? 24'd0 :
                               saturate(last.x_neg, last.x_sat, last.x_work);
                point_y_reg <= (cfg.focal_y == 16'd0) ? 24'd0 :
                               saturate(last.y_neg, last.y_sat, last.y_work);
            end
        end
    end

endmodule

// ----- hw/rtl/stereo_match_triangulator.sv -----
// ----------------------------------------------------------------------------
// stereo_match_triangulator
// Triangulates matched keypoint pairs of a rectified stereo camera into
// depth and lateral position, with a reason code for rejected pairs.
// ----------------------------------------------------------------------------
//  Channel  Direction  Content
//  s_*      in         pair: left_col, left_row, right_col, right_row
//  m_*      out        verdict in tuser; point_x, point_y, point_z in tdata
//  cfg_*    in         register writes, index 0 to 7
//
// One pair per cycle is accepted and one result per cycle is delivered while m_tready is high.
// Each pair passes a front register, the queue, then 24 depth
// division stages and 24 projection division stages, one quotient bit each.
// Reset clears the valid bits and loads the register defaults.
// A stalled output freezes the back pipeline; the queue keeps the front going.
// ----------------------------------------------------------------------------
module stereo_match_triangulator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // left_col, left_row, right_col, right_row
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // point_x, point_y, point_z
    output logic [2:0]  m_tuser    // verdict
);
    import smt_pkg::*;

    cfg_t        cfg_reg;
    logic        queue_full;
    logic        queue_empty;
    logic        push;
    logic        pop;
    job_t        push_job;
    job_t        pop_job;
    logic [23:0] point_x;
    logic [23:0] point_y;
    logic [23:0] point_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_x       <= 16'd8192;
            cfg_reg.focal_y       <= 16'd8192;
            cfg_reg.center_x      <= 16'd5120;
            cfg_reg.center_y      <= 16'd3840;
            cfg_reg.baseline      <= 16'd2048;
            cfg_reg.row_tolerance <= 16'd32;
            cfg_reg.min_disparity <= 16'd48;
            cfg_reg.max_depth     <= 24'd3276800;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FOCAL_X:       cfg_reg.focal_x       <= cfg_data[15:0];
                CFG_FOCAL_Y:       cfg_reg.focal_y       <= cfg_data[15:0];
                CFG_CENTER_X:      cfg_reg.center_x      <= cfg_data[15:0];
                CFG_CENTER_Y:      cfg_reg.center_y      <= cfg_data[15:0];
                CFG_BASELINE:      cfg_reg.baseline      <= cfg_data[15:0];
                CFG_ROW_TOLERANCE: cfg_reg.row_tolerance <= cfg_data[15:0];
                CFG_MIN_DISPARITY: cfg_reg.min_disparity <= cfg_data[15:0];
                CFG_MAX_DEPTH:     cfg_reg.max_depth     <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    smt_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .left_col   (s_tdata[15:0]),
        .left_row   (s_tdata[31:16]),
        .right_col  (s_tdata[47:32]),
        .right_row  (s_tdata[63:48]),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    smt_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    smt_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .queue_empty (queue_empty),
        .job         (pop_job),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .verdict     (m_tuser),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z)
    );

    assign m_tdata = {point_z, point_y, point_x};

endmodule
